[rtl/ipu_pkg.sv]
// ----------------------------------------------------------------------------
// ipu_pkg
// Shared types and constants of the integer pixel upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package ipu_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_SCALE_DEF  = 16;

    // field widths of the registers and ports
    localparam int DIM_W   = 11;
    localparam int SCALE_W = 5;
    localparam int PIX_W   = 16;
    localparam int DEST_W  = 28;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // register indexes
    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SCALE_FACTOR  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;   // latch a new item
        logic emit;   // write one result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic last_dy;    // the next result is the last one of the item
        logic out_valid;  // output register holds a result
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/ipu_regs.sv]
// ----------------------------------------------------------------------------
// ipu_regs
// APB register file; gives the clamped width, height and scale.
// ----------------------------------------------------------------------------
`default_nettype none

module ipu_regs #(
    parameter int MAX_WIDTH  = ipu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ipu_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_SCALE  = ipu_pkg::MAX_SCALE_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ipu_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ipu_pkg::DATA_W-1:0]   pwdata,
    output logic      [ipu_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic                              o_cfg_clear,
    output logic      [ipu_pkg::DIM_W-1:0]    o_width,
    output logic      [ipu_pkg::DIM_W-1:0]    o_height,
    output logic      [ipu_pkg::SCALE_W-1:0]  o_scale
);
    import ipu_pkg::*;

    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [SCALE_W-1:0] r_scale;
    logic [1:0]         wr_index;
    logic               wr_en;

    assign pready   = 1'b1;
    assign wr_index = paddr[3:2];
    assign wr_en    = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_scale  <= SCALE_W'(1);
        end else if (wr_en) begin
            case (wr_index)
                REG_SOURCE_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_SOURCE_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                REG_SCALE_FACTOR:  r_scale  <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // a write to a known register restarts the frame
    always_comb begin
        o_cfg_clear = 1'b0;
        if (wr_en) begin
            case (wr_index)
                REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT, REG_SCALE_FACTOR: o_cfg_clear = 1'b1;
                default: o_cfg_clear = 1'b0;
            endcase
        end
    end

    always_comb begin
        case (wr_index)
            REG_SOURCE_WIDTH:  prdata = DATA_W'(r_width);
            REG_SOURCE_HEIGHT: prdata = DATA_W'(r_height);
            REG_SCALE_FACTOR:  prdata = DATA_W'(r_scale);
            default:           prdata = '0;
        endcase
    end

    // zero reads as one, large values saturate
    always_comb begin
        if (r_width == '0)
            o_width = DIM_W'(1);
        else if (32'(r_width) > MAX_WIDTH)
            o_width = DIM_W'(MAX_WIDTH);
        else
            o_width = r_width;

        if (r_height == '0)
            o_height = DIM_W'(1);
        else if (32'(r_height) > MAX_HEIGHT)
            o_height = DIM_W'(MAX_HEIGHT);
        else
            o_height = r_height;

        if (r_scale == '0)
            o_scale = SCALE_W'(1);
        else if (32'(r_scale) > MAX_SCALE)
            o_scale = SCALE_W'(MAX_SCALE);
        else
            o_scale = r_scale;
    end

endmodule

`default_nettype wire

[rtl/ipu_ctrl.sv]
// ----------------------------------------------------------------------------
// ipu_ctrl
// Controller: takes an item, then steps the datapath once per scaled row.
// ----------------------------------------------------------------------------
`default_nettype none

module ipu_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_out_ready,
    input  wire ipu_pkg::t_dp_status   i_status,
    output ipu_pkg::t_dp_cmd           o_cmd
);
    import ipu_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   slot_free;

    assign slot_free = !i_status.out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (slot_free && i_status.last_dy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_RUN: begin
                o_cmd.emit = slot_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[rtl/ipu_dp.sv]
// ----------------------------------------------------------------------------
// ipu_dp
// Datapath: source counters, destination index accumulators, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipu_dp #(
    parameter int MAX_WIDTH  = ipu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ipu_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_SCALE  = ipu_pkg::MAX_SCALE_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ipu_pkg::t_dp_cmd             i_cmd,
    output ipu_pkg::t_dp_status               o_status,
    input  wire logic                         i_cfg_clear,
    input  wire logic [ipu_pkg::DIM_W-1:0]    i_width,
    input  wire logic [ipu_pkg::DIM_W-1:0]    i_height,
    input  wire logic [ipu_pkg::SCALE_W-1:0]  i_scale,
    input  wire logic [ipu_pkg::PIX_W-1:0]    i_pixel_value,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic      [ipu_pkg::PIX_W-1:0]    o_fill_value,
    output logic      [ipu_pkg::DEST_W-1:0]   o_dest_index,
    output logic      [ipu_pkg::SCALE_W-1:0]  o_run_length,
    output logic                              o_last_of_run,
    output logic                              o_frame_done
);
    import ipu_pkg::*;

    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DW = (MAX_SCALE  > 1) ? $clog2(MAX_SCALE)  : 1;

    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [DW-1:0]     r_dy;
    logic [DEST_W-1:0] r_row_base;   // row*s*dst_w
    logic [DEST_W-1:0] r_row_acc;    // row_base + dy*dst_w
    logic [DEST_W-1:0] r_col_off;    // col*s
    logic [DEST_W-1:0] r_dst_w;
    logic [PIX_W-1:0]  r_pix;
    logic              r_last_col;
    logic              r_last_row;
    logic              r_out_valid;

    logic [15:0]       dst_w_prod;
    logic              last_dy;
    logic [DEST_W-1:0] n_row_acc;

    assign dst_w_prod = {5'b0, i_width} * {11'b0, i_scale};
    assign last_dy    = (6'(r_dy) + 6'd1) == 6'(i_scale);
    assign n_row_acc  = r_row_acc + r_dst_w;

    assign o_status.last_dy   = last_dy;
    assign o_status.out_valid = r_out_valid;
    assign o_out_valid        = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_dy        <= '0;
            r_row_base  <= '0;
            r_row_acc   <= '0;
            r_col_off   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_clear) begin
                r_col      <= '0;
                r_row      <= '0;
                r_row_base <= '0;
                r_row_acc  <= '0;
                r_col_off  <= '0;
            end else if (i_cmd.load) begin
                r_dy <= '0;
            end else if (i_cmd.emit) begin
                if (!last_dy) begin
                    r_dy      <= r_dy + DW'(1);
                    r_row_acc <= n_row_acc;
                end else if (r_last_col) begin
                    r_col     <= '0;
                    r_col_off <= '0;
                    if (r_last_row) begin
                        r_row      <= '0;
                        r_row_base <= '0;
                        r_row_acc  <= '0;
                    end else begin
                        // accumulator has walked s rows: next source row start
                        r_row      <= r_row + RW'(1);
                        r_row_base <= n_row_acc;
                        r_row_acc  <= n_row_acc;
                    end
                end else begin
                    r_col     <= r_col + CW'(1);
                    r_col_off <= r_col_off + DEST_W'(i_scale);
                    r_row_acc <= r_row_base;
                end
            end
        end
    end

    // item payload and flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix      <= i_pixel_value;
            r_dst_w    <= DEST_W'(dst_w_prod);
            r_last_col <= (32'(r_col) + 32'd1) >= 32'(i_width);
            r_last_row <= (32'(r_row) + 32'd1) >= 32'(i_height);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_fill_value  <= r_pix;
            o_dest_index  <= r_row_acc + r_col_off;
            o_run_length  <= i_scale;
            o_last_of_run <= last_dy;
            o_frame_done  <= r_last_col && r_last_row;
        end
    end

endmodule

`default_nettype wire

[rtl/integer_pixel_upscaler_unit.sv]
// ----------------------------------------------------------------------------
// integer_pixel_upscaler_unit
// Nearest-neighbor integer upscaler for RGB565 pixels in raster order.
// ----------------------------------------------------------------------------
//  channel   direction  signals                                   accept
//  input     in         i_in_valid/o_in_ready, i_pixel_value      valid && ready
//  output    out        o_out_valid/i_out_ready, o_fill_value,    valid && ready
//                       o_dest_index, o_run_length,
//                       o_last_of_run, o_frame_done
//  config    in         psel/penable/pwrite/paddr/pwdata/prdata   psel&penable&pwrite
//
//  an item gives scale results, one per cycle from the output register while
//  the output is not stalled, and the next item can be taken the cycle after
//  its last result is loaded.
//  an output stall holds the controller; the last result of an item may wait
//  while the next item is accepted.
//  synchronous active-low reset clears counters, state and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_pixel_upscaler_unit #(
    parameter int MAX_WIDTH  = ipu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ipu_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_SCALE  = ipu_pkg::MAX_SCALE_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ipu_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ipu_pkg::DATA_W-1:0]   pwdata,
    output logic      [ipu_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [ipu_pkg::PIX_W-1:0]    i_pixel_value,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [ipu_pkg::PIX_W-1:0]    o_fill_value,
    output logic      [ipu_pkg::DEST_W-1:0]   o_dest_index,
    output logic      [ipu_pkg::SCALE_W-1:0]  o_run_length,
    output logic                              o_last_of_run,
    output logic                              o_frame_done
);
    import ipu_pkg::*;

    logic               cfg_clear;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [SCALE_W-1:0] scale;
    t_dp_cmd            cmd;
    t_dp_status         status;

    ipu_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_SCALE  (MAX_SCALE)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_cfg_clear (cfg_clear),
        .o_width     (width),
        .o_height    (height),
        .o_scale     (scale)
    );

    ipu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ipu_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_SCALE  (MAX_SCALE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_clear   (cfg_clear),
        .i_width       (width),
        .i_height      (height),
        .i_scale       (scale),
        .i_pixel_value (i_pixel_value),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_fill_value  (o_fill_value),
        .o_dest_index  (o_dest_index),
        .o_run_length  (o_run_length),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done)
    );

endmodule

`default_nettype wire

[rtl/ipu_checker.sv]
// ----------------------------------------------------------------------------
// ipu_checker
// Port-level checks of the upscaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ipu_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [ipu_pkg::PIX_W-1:0]    o_fill_value,
    input wire logic [ipu_pkg::DEST_W-1:0]   o_dest_index,
    input wire logic                         o_last_of_run
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_dest_index)))
        else $error("stalled result changed");

    // results of one item follow each other with the same pixel
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_of_run) |=>
            (o_out_valid && $stable(o_fill_value)))
        else $error("item results broken up");

    // no new item while results of the current one are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_of_run) |-> !o_in_ready)
        else $error("item accepted during a run");

    // an accepted item blocks the input on the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after accept");

endmodule

bind integer_pixel_upscaler_unit ipu_checker u_ipu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_fill_value  (o_fill_value),
    .o_dest_index  (o_dest_index),
    .o_last_of_run (o_last_of_run)
);

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the integer pixel upscaler. A short directed table
// covers reset values, register masking and clamping, the unused register
// slot and frame wrap. It is followed by random frames with random register
// settings and random stalls on both channels. Results of typed rows are
// checked against the table, the rest against an in-bench row expansion model.
// ----------------------------------------------------------------------------
module tb;
    import ipu_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_AFTER  = 440;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PRINTS   = 100;
    localparam int DIR_ROWS     = 36;

    // slot past the register list, writes there must be ignored
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0]   fill;
        logic [DEST_W-1:0]  dest;
        logic [SCALE_W-1:0] length;
        logic               last;
        logic               frame;
    } t_fill_run;

    typedef enum logic {
        ROW_CFG,
        ROW_PIX
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [1:0]        reg_idx;
        logic [DATA_W-1:0] data;
        logic              typed;
        t_fill_run         want;
    } t_stim_row;

    localparam t_stim_row DIRECTED_ROWS [DIR_ROWS] = '{
        // reset values: width 1, height 1, scale 1
        '{ROW_PIX, 2'd0, 32'h0000_0000, 1'b1, '{16'h0000, 28'd0, 5'd1, 1'b1, 1'b1}},
        '{ROW_PIX, 2'd0, 32'h0000_FFFF, 1'b1, '{16'hFFFF, 28'd0, 5'd1, 1'b1, 1'b1}},
        '{ROW_PIX, 2'd0, 32'h0000_5555, 1'b1, '{16'h5555, 28'd0, 5'd1, 1'b1, 1'b1}},
        '{ROW_PIX, 2'd0, 32'h0000_AAAA, 1'b1, '{16'hAAAA, 28'd0, 5'd1, 1'b1, 1'b1}},
        // values that mask down to zero, all treated as 1
        '{ROW_CFG, REG_SOURCE_WIDTH,  32'hFFFF_F800, 1'b0, '0},
        '{ROW_CFG, REG_SOURCE_HEIGHT, 32'h0000_0000, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_FACTOR,  32'hFFFF_FFE0, 1'b0, '0},
        '{ROW_PIX, 2'd0, 32'h0000_1234, 1'b1, '{16'h1234, 28'd0, 5'd1, 1'b1, 1'b1}},
        '{ROW_PIX, 2'd0, 32'h0000_F800, 1'b1, '{16'hF800, 28'd0, 5'd1, 1'b1, 1'b1}},
        // everything above its maximum, saturated
        '{ROW_CFG, REG_SOURCE_WIDTH,  32'h0000_07FF, 1'b0, '0},
        '{ROW_CFG, REG_SOURCE_HEIGHT, 32'h0000_07FF, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_FACTOR,  32'h0000_001F, 1'b0, '0},
        '{ROW_PIX, 2'd0, 32'h0000_8001, 1'b0, '0},
        '{ROW_PIX, 2'd0, 32'h0000_7FFE, 1'b0, '0},
        '{ROW_PIX, 2'd0, 32'h0000_0F0F, 1'b0, '0},
        // one pixel frame at full scale
        '{ROW_CFG, REG_SOURCE_WIDTH,  32'h0000_0001, 1'b0, '0},
        '{ROW_CFG, REG_SOURCE_HEIGHT, 32'h0000_0001, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_FACTOR,  32'h0000_0010, 1'b0, '0},
        '{ROW_PIX, 2'd0, 32'h0000_07E0, 1'b0, '0},
        // 3x2 frame, spare write mid frame must not restart it
        '{ROW_CFG, REG_SOURCE_WIDTH,  32'h0000_0003, 1'b0, '0},
        '{ROW_CFG, REG_SOURCE_HEIGHT, 32'h0000_0002, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_FACTOR,  32'h0000_0002, 1'b0, '0},
        '{ROW_PIX, 2'd0, 32'h0000_001F, 1'b0, '0},
        '{ROW_PIX, 2'd0, 32'h0000_F81F, 1'b0, '0},
        '{ROW_CFG, REG_SPARE,         32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_PIX, 2'd0, 32'h0000_C3C3, 1'b0, '0},
        '{ROW_PIX, 2'd0, 32'h0000_3C3C, 1'b0, '0},
        '{ROW_PIX, 2'd0, 32'h0000_FFE0, 1'b0, '0},
        '{ROW_PIX, 2'd0, 32'h0000_0001, 1'b0, '0},
        '{ROW_PIX, 2'd0, 32'h0000_8000, 1'b0, '0},
        '{ROW_CFG, REG_SOURCE_WIDTH,  32'h0000_0004, 1'b0, '0},
        '{ROW_CFG, REG_SOURCE_HEIGHT, 32'h0000_0003, 1'b0, '0},
        '{ROW_CFG, REG_SCALE_FACTOR,  32'h0000_0003, 1'b0, '0},
        '{ROW_PIX, 2'd0, 32'h0000_0002, 1'b0, '0},
        '{ROW_PIX, 2'd0, 32'h0000_4000, 1'b0, '0},
        '{ROW_PIX, 2'd0, 32'h0000_FFFF, 1'b0, '0}
    };

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [ADDR_W-1:0]  paddr         = '0;
    logic [DATA_W-1:0]  pwdata        = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic [PIX_W-1:0]   i_pixel_value = '0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic [PIX_W-1:0]   o_fill_value;
    logic [DEST_W-1:0]  o_dest_index;
    logic [SCALE_W-1:0] o_run_length;
    logic               o_last_of_run;
    logic               o_frame_done;

    // model state
    logic [DIM_W-1:0]   cfg_width;
    logic [DIM_W-1:0]   cfg_height;
    logic [SCALE_W-1:0] cfg_scale;
    logic [9:0]         col_pos;
    logic [9:0]         row_pos;

    t_fill_run fill_runs_due [$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    bit        quiet          = 1'b0;

    integer_pixel_upscaler_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_value (i_pixel_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_fill_value  (o_fill_value),
        .o_dest_index  (o_dest_index),
        .o_run_length  (o_run_length),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        mismatch_count++;
    endtask

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void apply_reg(input logic [1:0] idx, input logic [DATA_W-1:0] wdata);
        case (idx)
            REG_SOURCE_WIDTH:  cfg_width  = wdata[DIM_W-1:0];
            REG_SOURCE_HEIGHT: cfg_height = wdata[DIM_W-1:0];
            REG_SCALE_FACTOR:  cfg_scale  = wdata[SCALE_W-1:0];
            default:           return;
        endcase
        col_pos = '0;
        row_pos = '0;
    endfunction

    // one run per scaled row, top to bottom
    function automatic void expand_pixel(input logic [PIX_W-1:0] pix, input logic keep);
        int unsigned w;
        int unsigned h;
        int unsigned s;
        int unsigned col;
        int unsigned row;
        int unsigned dst_w;
        int unsigned idx;
        logic        last_col;
        logic        last_row;
        t_fill_run   seg;
        w = clamp_to(cfg_width, MAX_WIDTH_DEF);
        h = clamp_to(cfg_height, MAX_HEIGHT_DEF);
        s = clamp_to(cfg_scale, MAX_SCALE_DEF);
        col = col_pos;
        row = row_pos;
        dst_w = w * s;
        last_col = (col + 1 >= w);
        last_row = (row + 1 >= h);
        for (int unsigned dy = 0; dy < s; dy++) begin
            idx = (row * s + dy) * dst_w + col * s;
            seg.fill   = pix;
            seg.dest   = idx[DEST_W-1:0];
            seg.length = s[SCALE_W-1:0];
            seg.last   = (dy + 1 == s);
            seg.frame  = last_col && last_row;
            if (keep) fill_runs_due.push_back(seg);
        end
        if (last_col) begin
            col_pos = '0;
            row_pos = last_row ? '0 : row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endfunction

    function automatic logic [DATA_W-1:0] rand_reg_value(input logic [1:0] idx);
        logic [DATA_W-1:0] v;
        int unsigned       pick;
        int unsigned       sh;
        pick = $urandom_range(0, 15);
        if (idx == REG_SCALE_FACTOR) begin
            sh = SCALE_W;
            case (pick)
                0:       v = 0;
                1:       v = MAX_SCALE_DEF;
                2:       v = $urandom_range(MAX_SCALE_DEF + 1, 31);
                3:       v = 1;
                default: v = $urandom_range(1, MAX_SCALE_DEF);
            endcase
        end else begin
            sh = DIM_W;
            case (pick)
                0:       v = 0;
                1:       v = MAX_WIDTH_DEF;
                2:       v = $urandom_range(MAX_WIDTH_DEF + 1, 2047);
                3:       v = 2047;
                4:       v = 1;
                default: v = $urandom_range(1, 6);
            endcase
        end
        // junk in the bits above the register
        if ($urandom_range(0, 3) == 0) v = v | ($urandom << sh);
        return v;
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic typed,
                              input t_fill_run want);
        i_in_valid    <= 1'b1;
        i_pixel_value <= pix;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expand_pixel(pix, !typed);
        if (typed) fill_runs_due.push_back(want);
    endtask

    task automatic maybe_pause();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // only while no result is outstanding
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] wdata);
        i_in_valid <= 1'b0;
        while (fill_runs_due.size() != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg(idx, wdata);
        @(posedge i_clk);
    endtask

    // output side stalls
    initial begin
        @(posedge i_clk);
        forever begin
            if (quiet) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_fill_run want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (fill_runs_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result, dest_index %0d", o_dest_index));
            end else begin
                want = fill_runs_due.pop_front();
                if (o_fill_value !== want.fill)
                    flag_mismatch($sformatf("fill_value %h, want %h",
                                            o_fill_value, want.fill));
                if (o_dest_index !== want.dest)
                    flag_mismatch($sformatf("dest_index %0d, want %0d",
                                            o_dest_index, want.dest));
                if (o_run_length !== want.length)
                    flag_mismatch($sformatf("run_length %0d, want %0d",
                                            o_run_length, want.length));
                if (o_last_of_run !== want.last)
                    flag_mismatch($sformatf("last_of_run %b, want %b",
                                            o_last_of_run, want.last));
                if (o_frame_done !== want.frame)
                    flag_mismatch($sformatf("frame_done %b, want %b",
                                            o_frame_done, want.frame));
            end
        end
    end

    initial begin
        int unsigned sent;
        int unsigned burst;
        cfg_width  = 1;
        cfg_height = 1;
        cfg_scale  = 1;
        col_pos    = '0;
        row_pos    = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
                write_reg(DIRECTED_ROWS[r].reg_idx, DIRECTED_ROWS[r].data);
            end else begin
                send_pixel(DIRECTED_ROWS[r].data[PIX_W-1:0], DIRECTED_ROWS[r].typed,
                           DIRECTED_ROWS[r].want);
                maybe_pause();
            end
        end

        // random frames, each burst under a fresh mix of register writes
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_SOURCE_WIDTH, rand_reg_value(REG_SOURCE_WIDTH));
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_SOURCE_HEIGHT, rand_reg_value(REG_SOURCE_HEIGHT));
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_SCALE_FACTOR, rand_reg_value(REG_SCALE_FACTOR));
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_SPARE, $urandom);
            burst = $urandom_range(8, 40);
            repeat (burst) begin
                if (sent >= QUIET_AFTER) quiet = 1'b1;
                send_pixel(PIX_W'($urandom), 1'b0, '0);
                sent++;
                maybe_pause();
            end
        end

        i_in_valid <= 1'b0;
        while (fill_runs_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/ipu_pkg.sv
rtl/ipu_regs.sv
rtl/ipu_ctrl.sv
rtl/ipu_dp.sv
rtl/integer_pixel_upscaler_unit.sv
rtl/ipu_checker.sv
test/tb.sv
